[hw/rtl/ntt_mac_pkg.sv]
// Shared types and constants for the NTT-domain multiply-accumulate core.
// Used by every module in hw/rtl; depends on nothing.
package ntt_mac_pkg;

    localparam int POLY_DEGREE = 2048;
    localparam int MAX_MODULI  = 2;
    localparam int ACC_DEPTH   = POLY_DEGREE * MAX_MODULI;
    localparam int ADDR_W      = $clog2(ACC_DEPTH);
    localparam int DATA_W      = 61;
    localparam int SUM_W       = DATA_W + 1;
    localparam int WIDE_W      = DATA_W + 2;
    localparam int INDEX_W     = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int STAGES      = 2 * DATA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS_ZERO = 1'b0,
        REG_MODULUS_ONE  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               first;
        logic               last;
        logic               qz;
        logic [DATA_W-1:0]  q;
        logic [SUM_W-1:0]   q2;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  dsh;
        logic [DATA_W-1:0]  g0;
        logic [DATA_W-1:0]  g1;
        logic [DATA_W-1:0]  r0;
        logic [DATA_W-1:0]  r1;
    } item_t;

endpackage

[hw/rtl/ntt_mac_red_stage.sv]
// One pipeline stage of the digit reduction: one bit of the digit enters the remainder.
// Depends on ntt_mac_pkg.
module ntt_mac_red_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  ntt_mac_pkg::item_t  in_item,
    output logic                out_valid,
    output ntt_mac_pkg::item_t  out_item
);
    import ntt_mac_pkg::*;

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] qx;
    logic [SUM_W-1:0] t_red;

    always_comb
    begin
        qx    = {1'b0, in_item.q};
        t     = {in_item.a, in_item.dsh[DATA_W-1]};
        t_red = (t >= qx) ? (t - qx) : t;
        item_next     = in_item;
        item_next.a   = t_red[DATA_W-1:0];
        item_next.dsh = {in_item.dsh[DATA_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/ntt_mac_mul_stage.sv]
// One pipeline stage of the modular multiply: one bit of each GSW coefficient.
// Depends on ntt_mac_pkg.
module ntt_mac_mul_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  ntt_mac_pkg::item_t  in_item,
    output logic                out_valid,
    output ntt_mac_pkg::item_t  out_item
);
    import ntt_mac_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    function automatic logic [DATA_W-1:0] mul_step(
        input logic [DATA_W-1:0] r,
        input logic              bit_in,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] q,
        input logic [SUM_W-1:0]  q2
    );
        logic [WIDE_W-1:0] t;
        logic [WIDE_W-1:0] qx;
        logic [WIDE_W-1:0] q2x;
        logic [WIDE_W-1:0] res;
        qx  = {2'b00, q};
        q2x = {1'b0, q2};
        t   = {1'b0, r, 1'b0} + (bit_in ? {2'b00, a} : {WIDE_W{1'b0}});
        if (t >= q2x)
        begin
            res = t - q2x;
        end
        else if (t >= qx)
        begin
            res = t - qx;
        end
        else
        begin
            res = t;
        end
        return res[DATA_W-1:0];
    endfunction

    always_comb
    begin
        item_next    = in_item;
        item_next.r0 = mul_step(in_item.r0, in_item.g0[DATA_W-1], in_item.a,
                                in_item.q, in_item.q2);
        item_next.r1 = mul_step(in_item.r1, in_item.g1[DATA_W-1], in_item.a,
                                in_item.q, in_item.q2);
        item_next.g0 = {in_item.g0[DATA_W-2:0], 1'b0};
        item_next.g1 = {in_item.g1[DATA_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/ntt_mac_acc.sv]
// Accumulator memory with read forwarding, a slow reducer for sums that are not
// below the current modulus, the output register and the pipeline stall. Uses ntt_mac_pkg.
module ntt_mac_acc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_valid,
    input  ntt_mac_pkg::item_t                  m_item,
    output logic                                advance,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ntt_mac_pkg::INDEX_W-1:0]     out_index,
    output logic [ntt_mac_pkg::DATA_W-1:0]      result_first,
    output logic [ntt_mac_pkg::DATA_W-1:0]      result_second
);
    import ntt_mac_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } slow_state_t;

    logic [2*DATA_W-1:0] mem [0:ACC_DEPTH-1];
    logic [2*DATA_W-1:0] rd_reg;
    logic [2*DATA_W-1:0] fwd_reg;
    logic                fwd_hit_reg;
    logic                a_valid_reg;
    item_t               a_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [DATA_W-1:0]   res0_reg;
    logic [DATA_W-1:0]   res1_reg;

    slow_state_t         state_reg;
    slow_state_t         state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [SUM_W-1:0]    sv0_reg;
    logic [SUM_W-1:0]    sv1_reg;
    logic [SUM_W-1:0]    sv0_next;
    logic [SUM_W-1:0]    sv1_next;
    logic [DATA_W-1:0]   rem0_reg;
    logic [DATA_W-1:0]   rem1_reg;
    logic [DATA_W-1:0]   rem0_next;
    logic [DATA_W-1:0]   rem1_next;

    logic [ADDR_W-1:0]   a_slot;
    logic [ADDR_W-1:0]   m_slot;
    logic [DATA_W-1:0]   acc0;
    logic [DATA_W-1:0]   acc1;
    logic [SUM_W-1:0]    qx;
    logic [SUM_W-1:0]    s0;
    logic [SUM_W-1:0]    s1;
    logic [SUM_W-1:0]    f0;
    logic [SUM_W-1:0]    f1;
    logic                big;
    logic                blocked;
    logic [DATA_W-1:0]   new0;
    logic [DATA_W-1:0]   new1;

    function automatic logic [DATA_W-1:0] rem_step(
        input logic [DATA_W-1:0] rem,
        input logic              bit_in,
        input logic [SUM_W-1:0]  q
    );
        logic [SUM_W-1:0] t;
        logic [SUM_W-1:0] res;
        t   = {rem, bit_in};
        res = (t >= q) ? (t - q) : t;
        return res[DATA_W-1:0];
    endfunction

    assign a_slot = ADDR_W'(a_item_reg.index);
    assign m_slot = ADDR_W'(m_item.index);

    always_comb
    begin
        acc0 = fwd_hit_reg ? fwd_reg[DATA_W-1:0] : rd_reg[DATA_W-1:0];
        acc1 = fwd_hit_reg ? fwd_reg[2*DATA_W-1:DATA_W] : rd_reg[2*DATA_W-1:DATA_W];
        qx   = {1'b0, a_item_reg.q};
        s0   = {1'b0, acc0} + {1'b0, a_item_reg.r0};
        s1   = {1'b0, acc1} + {1'b0, a_item_reg.r1};
        f0   = (s0 >= qx) ? (s0 - qx) : s0;
        f1   = (s1 >= qx) ? (s1 - qx) : s1;
        big  = !a_item_reg.first && !a_item_reg.qz &&
               (({1'b0, acc0} >= qx) || ({1'b0, acc1} >= qx));
        if (a_item_reg.qz)
        begin
            new0 = '0;
            new1 = '0;
        end
        else if (a_item_reg.first)
        begin
            new0 = a_item_reg.r0;
            new1 = a_item_reg.r1;
        end
        else if (big)
        begin
            new0 = rem0_reg;
            new1 = rem1_reg;
        end
        else
        begin
            new0 = f0[DATA_W-1:0];
            new1 = f1[DATA_W-1:0];
        end
        blocked = a_valid_reg && big && (state_reg != ST_DONE);
        advance = (!out_valid_reg || out_ready) && !blocked;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sv0_next   = sv0_reg;
        sv1_next   = sv1_reg;
        rem0_next  = rem0_reg;
        rem1_next  = rem1_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (a_valid_reg && big)
                begin
                    sv0_next   = s0;
                    sv1_next   = s1;
                    rem0_next  = '0;
                    rem1_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem0_next = rem_step(rem0_reg, sv0_reg[SUM_W-1], qx);
                rem1_next = rem_step(rem1_reg, sv1_reg[SUM_W-1], qx);
                sv0_next  = {sv0_reg[SUM_W-2:0], 1'b0};
                sv1_next  = {sv1_reg[SUM_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = a_valid_reg && a_item_reg.last;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                a_valid_reg <= m_valid;
                fwd_hit_reg <= a_valid_reg && m_valid && (a_slot == m_slot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sv0_reg  <= sv0_next;
        sv1_reg  <= sv1_next;
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        if (advance)
        begin
            a_item_reg <= m_item;
            fwd_reg    <= {new1, new0};
            if (a_valid_reg && a_item_reg.last)
            begin
                out_index_reg <= a_item_reg.index;
                res0_reg      <= new0;
                res1_reg      <= new1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (a_valid_reg)
            begin
                mem[a_slot] <= {new1, new0};
            end
            rd_reg <= mem[m_slot];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_index     = out_index_reg;
    assign result_first  = res0_reg;
    assign result_second = res1_reg;

endmodule

[hw/rtl/ntt_domain_mac_mod_reduce_core.sv]
// Top level of the NTT-domain multiply-accumulate core with modular reduction.
// Depends on ntt_mac_pkg, ntt_mac_red_stage, ntt_mac_mul_stage and ntt_mac_acc.
//
// The core accepts one item per clock cycle unless the pipeline is held. Of its stages,
// 61 reduce the digit modulo the selected modulus one bit per stage, 61 form both modular
// products one coefficient bit per stage, one updates the accumulator memory and one
// register holds the result. Back-to-back items on the same index are served by
// forwarding. When a stored sum is not below the modulus of the item that adds to it
// (the modulus or the select changed within a sum), the accumulate stage holds the
// pipeline while a bit-serial reducer brings the sum into range. A stalled output
// stalls the whole pipeline.
module ntt_domain_mac_mod_reduce_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [ntt_mac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntt_mac_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [ntt_mac_pkg::INDEX_W-1:0]         coeff_index,
    input  logic                                    modulus_select,
    input  logic [ntt_mac_pkg::DATA_W-1:0]          digit_value,
    input  logic [ntt_mac_pkg::DATA_W-1:0]          gsw_coeff_first,
    input  logic [ntt_mac_pkg::DATA_W-1:0]          gsw_coeff_second,
    input  logic                                    first_row,
    input  logic                                    last_row,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ntt_mac_pkg::INDEX_W-1:0]         out_index,
    output logic [ntt_mac_pkg::DATA_W-1:0]          result_first,
    output logic [ntt_mac_pkg::DATA_W-1:0]          result_second
);
    import ntt_mac_pkg::*;

    logic [DATA_W-1:0] modulus_zero_reg;
    logic [DATA_W-1:0] modulus_one_reg;
    logic [DATA_W-1:0] q_sel;
    logic              advance;
    logic              pipe_valid [0:STAGES];
    item_t             pipe_item  [0:STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_zero_reg <= '1;
            modulus_one_reg  <= '1;
        end
        else if (cfg_write_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_MODULUS_ZERO: modulus_zero_reg <= cfg_data;
                REG_MODULUS_ONE:  modulus_one_reg  <= cfg_data;
                default:          modulus_zero_reg <= modulus_zero_reg;
            endcase
        end
    end

    always_comb
    begin
        q_sel = (modulus_select && (MAX_MODULI > 1)) ? modulus_one_reg : modulus_zero_reg;
        pipe_valid[0]       = in_valid;
        pipe_item[0].index  = coeff_index;
        pipe_item[0].first  = first_row;
        pipe_item[0].last   = last_row;
        pipe_item[0].qz     = (q_sel < DATA_W'(2));
        pipe_item[0].q      = q_sel;
        pipe_item[0].q2     = {q_sel, 1'b0};
        pipe_item[0].a      = '0;
        pipe_item[0].dsh    = digit_value;
        pipe_item[0].g0     = gsw_coeff_first;
        pipe_item[0].g1     = gsw_coeff_second;
        pipe_item[0].r0     = '0;
        pipe_item[0].r1     = '0;
    end

    genvar i;
    generate
        for (i = 0; i < DATA_W; i++)
        begin : g_red
            ntt_mac_red_stage u_red (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (pipe_valid[i]),
                .in_item   (pipe_item[i]),
                .out_valid (pipe_valid[i+1]),
                .out_item  (pipe_item[i+1])
            );
        end
        for (i = DATA_W; i < STAGES; i++)
        begin : g_mul
            ntt_mac_mul_stage u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (pipe_valid[i]),
                .in_item   (pipe_item[i]),
                .out_valid (pipe_valid[i+1]),
                .out_item  (pipe_item[i+1])
            );
        end
    endgenerate

    ntt_mac_acc u_acc (
        .clk           (clk),
        .rst_n         (rst_n),
        .m_valid       (pipe_valid[STAGES]),
        .m_item        (pipe_item[STAGES]),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_index     (out_index),
        .result_first  (result_first),
        .result_second (result_second)
    );

    assign in_ready = advance;

endmodule

[sim/tb_ntt_domain_mac_mod_reduce_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ntt_domain_mac_mod_reduce_core: random and directed items
// through valid/ready channels, checked against a modular multiply-accumulate predictor.
// Depends on ntt_mac_pkg and the core RTL.
module tb_ntt_domain_mac_mod_reduce_core;
    import ntt_mac_pkg::*;

    localparam logic [60:0] ALL_ONES = {61{1'b1}};
    localparam int STALL_LIMIT = 50000;

    typedef struct {
        logic [11:0] idx;
        logic        sel;
        logic [60:0] digit;
        logic [60:0] g0;
        logic [60:0] g1;
        logic        first;
        logic        last;
    } row_t;

    typedef struct {
        logic [11:0] idx;
        logic [60:0] r0;
        logic [60:0] r1;
    } sum_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [11:0] coeff_index = '0;
    logic modulus_select = 1'b0;
    logic [60:0] digit_value = '0;
    logic [60:0] gsw_coeff_first = '0;
    logic [60:0] gsw_coeff_second = '0;
    logic first_row = 1'b0;
    logic last_row = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [11:0] out_index;
    logic [60:0] result_first;
    logic [60:0] result_second;

    ntt_domain_mac_mod_reduce_core dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    row_t pending_rows[$];
    sum_t expected_sums[$];
    logic [60:0] q_zero = ALL_ONES;
    logic [60:0] q_one = ALL_ONES;
    logic [60:0] sum_first[4096];
    logic [60:0] sum_second[4096];
    bit gen_written[4096];
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    row_t cur_row;

    function automatic logic [60:0] mul_mod(logic [60:0] a, logic [60:0] b, logic [60:0] q);
        logic [121:0] aw;
        logic [121:0] bw;
        logic [121:0] p;
        if (q < 2)
            return '0;
        aw = a % q;
        bw = b % q;
        p = (aw * bw) % q;
        return p[60:0];
    endfunction

    function automatic logic [60:0] add_mod(logic [60:0] s, logic [60:0] p, logic [60:0] q);
        logic [61:0] t;
        if (q < 2)
            return '0;
        t = ({1'b0, s} + {1'b0, p}) % {1'b0, q};
        return t[60:0];
    endfunction

    task automatic accumulate_row(row_t r);
        logic [60:0] q;
        logic [60:0] p0;
        logic [60:0] p1;
        sum_t s;
        q = r.sel ? q_one : q_zero;
        p0 = mul_mod(r.digit, r.g0, q);
        p1 = mul_mod(r.digit, r.g1, q);
        if (r.first)
        begin
            sum_first[r.idx] = p0;
            sum_second[r.idx] = p1;
        end
        else
        begin
            sum_first[r.idx] = add_mod(sum_first[r.idx], p0, q);
            sum_second[r.idx] = add_mod(sum_second[r.idx], p1, q);
        end
        if (r.last)
        begin
            s.idx = r.idx;
            s.r0 = sum_first[r.idx];
            s.r1 = sum_second[r.idx];
            expected_sums = {expected_sums, s};
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                accumulate_row(cur_row);
            if (!in_valid || in_ready)
            begin
                if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_row = pending_rows.pop_front();
                    in_valid <= 1'b1;
                    coeff_index <= cur_row.idx;
                    modulus_select <= cur_row.sel;
                    digit_value <= cur_row.digit;
                    gsw_coeff_first <= cur_row.g0;
                    gsw_coeff_second <= cur_row.g1;
                    first_row <= cur_row.first;
                    last_row <= cur_row.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        sum_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: index %0d first %0h second %0h",
                                 out_index, result_first, result_second);
                end
                else
                begin
                    e = expected_sums.pop_front();
                    if (e.idx !== out_index || e.r0 !== result_first
                        || e.r1 !== result_second)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d %0h %0h, got %0d %0h %0h",
                                     e.idx, e.r0, e.r1, out_index, result_first,
                                     result_second);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (pending_rows.size() == 0 && !in_valid && expected_sums.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_ntt_domain_mac_mod_reduce_core NOT OK");
            $finish;
        end
    end

    task automatic add_row(logic [11:0] idx, logic sel, logic [60:0] d, logic [60:0] g0,
                           logic [60:0] g1, logic f, logic l);
        row_t r;
        r.idx = idx;
        r.sel = sel;
        r.digit = d;
        r.g0 = g0;
        r.g1 = g1;
        r.first = f | !gen_written[idx];
        r.last = l;
        gen_written[idx] = 1'b1;
        pending_rows = {pending_rows, r};
    endtask

    task automatic write_moduli(logic [60:0] m0, logic [60:0] m1);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_MODULUS_ZERO;
        cfg_data <= m0;
        @(posedge clk);
        cfg_index <= REG_MODULUS_ONE;
        cfg_data <= m1;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        q_zero = m0;
        q_one = m1;
    endtask

    // The pipeline is empty once it has advanced for longer than its depth with no input.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (pending_rows.size() > 0 || in_valid || expected_sums.size() > 0)
            @(posedge clk);
        while (quiet < 200)
        begin
            @(posedge clk);
            if (in_ready && !in_valid)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    function automatic logic [60:0] rand61();
        return 61'({$urandom(), $urandom()});
    endfunction

    function automatic logic [60:0] pick_operand(logic [60:0] q);
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            2: return q - 61'd1;
            3: return q;
            4: return q + 61'd1;
            default: return rand61();
        endcase
    endfunction

    function automatic logic [60:0] pick_modulus(int kind);
        logic [60:0] m;
        case (kind)
            0: m = 61'd2;
            1: m = ALL_ONES;
            2: m = 61'($urandom_range(65535));
            default: m = rand61();
        endcase
        return (m < 61'd2) ? 61'd3 : m;
    endfunction

    task automatic random_phase(int count);
        logic [11:0] pool[8];
        logic sel;
        logic [11:0] idx;
        logic [60:0] q;
        for (int i = 0; i < 8; i++)
            pool[i] = 12'($urandom_range(4095));
        pool[0] = 12'd0;
        pool[1] = 12'd4095;
        sel = $urandom_range(1);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
                sel = !sel;
            q = sel ? q_one : q_zero;
            if ($urandom_range(9) == 0)
            begin
                idx = 12'($urandom_range(4095));
                add_row(idx, $urandom_range(1), rand61(), rand61(), rand61(), 1'b1,
                        $urandom_range(1));
            end
            else
            begin
                idx = pool[$urandom_range(7)];
                add_row(idx, sel, pick_operand(q), pick_operand(q), pick_operand(q),
                        $urandom_range(4) == 0, $urandom_range(2) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_moduli(ALL_ONES, 61'd2);
        add_row(12'd0, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
        add_row(12'd4095, 1'b1, ALL_ONES, ALL_ONES, '0, 1'b1, 1'b1);
        add_row(12'd1, 1'b0, '0, ALL_ONES, 61'd5, 1'b1, 1'b0);
        add_row(12'd1, 1'b0, ALL_ONES - 1, ALL_ONES, ALL_ONES - 1, 1'b0, 1'b0);
        add_row(12'd1, 1'b0, 61'd7, 61'd9, 61'd11, 1'b0, 1'b1);
        add_row(12'd2, 1'b0, ALL_ONES - 1, ALL_ONES - 1, ALL_ONES - 2, 1'b1, 1'b0);
        add_row(12'd2, 1'b1, 61'd3, 61'd5, 61'd1, 1'b0, 1'b1);
        add_row(12'd3, 1'b1, 61'd1, 61'd1, 61'd3, 1'b1, 1'b0);
        add_row(12'd3, 1'b0, ALL_ONES, 61'd1, ALL_ONES - 1, 1'b0, 1'b1);
        add_row(12'd2048, 1'b0, 61'h155555555555555, 61'h0AAAAAAAAAAAAAAA,
                61'h155555555555555, 1'b1, 1'b0);
        add_row(12'd2048, 1'b0, 61'h0AAAAAAAAAAAAAAA, 61'h155555555555555,
                61'h0AAAAAAAAAAAAAAA, 1'b0, 1'b1);
        add_row(12'd5, 1'b1, 61'd2, 61'd3, 61'd4, 1'b0, 1'b0);
        add_row(12'd5, 1'b1, 61'd2, 61'd3, 61'd4, 1'b0, 1'b1);
        wait_idle();
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 11 : (ph < 4) ? 80 : 0;
            recv_idle = (ph < 2) ? 80 : (ph < 4) ? 11 : 0;
            write_moduli(pick_modulus((ph + 1) % 4), pick_modulus($urandom_range(3)));
            random_phase(117);
            wait_idle();
        end
        if (mismatches == 0)
            $display("tb_ntt_domain_mac_mod_reduce_core OK");
        else
            $display("tb_ntt_domain_mac_mod_reduce_core NOT OK");
        $finish;
    end
endmodule
